// ===== src/bltc_pkg.sv =====
// Shared types, opcode constants and helper functions of the tape machine.
package bltc_pkg;

  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 40;

  typedef enum logic [2:0] {
    FN_LOAD_PROG  = 3'd0,
    FN_WRITE_TAPE = 3'd1,
    FN_SET_IP     = 3'd2,
    FN_SET_DP     = 3'd3,
    FN_EXEC       = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_OP       = 2'd1,
    ST_BAD_SCAN     = 2'd2,
    ST_OUT_OF_STORE = 2'd3
  } status_e;

  localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
  localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] OP_IN    = 8'h2C;  // ','
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

  typedef enum logic [1:0] {
    OC_PLAIN,
    OC_OPEN,
    OC_CLOSE,
    OC_OTHER
  } op_class_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RED,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    func_e                func;
    logic [ADDR_W-1:0]    addr;
    logic [BYTE_W-1:0]    value;
    logic [BYTE_W-1:0]    io_in;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic                 out_valid;
    logic [BYTE_W-1:0]    out_byte;
    logic [ADDR_W-1:0]    ip_now;
    logic [ADDR_W-1:0]    dp_now;
  } res_t;

  typedef struct packed {
    logic    clr_write;
    logic    accept;
    logic    red_step;
    logic    apply;
    logic    exec_plain;
    logic    scan_start;
    logic    scan_fwd;
    logic    scan_step;
    logic    scan_hit;
    logic    status_wr;
    status_e status_code;
  } cmd_t;

  typedef struct packed {
    logic      clr_done;
    logic      red_done;
    op_class_e opc;
    logic      cell_zero;
    logic      ip_last;
    logic      ip_zero;
    logic      a_end;
    logic      scan_target;
    logic      depth_one;
  } sts_t;

  function automatic op_class_e op_class(input logic [7:0] b);
    op_class_e c;
    unique case (b) inside
      OP_RIGHT, OP_LEFT, OP_INC, OP_DEC, OP_OUT, OP_IN: c = OC_PLAIN;
      OP_OPEN:  c = OC_OPEN;
      OP_CLOSE: c = OC_CLOSE;
      default:  c = OC_OTHER;
    endcase
    return c;
  endfunction

  // Number of shifted compare-subtract steps that bring a 12-bit address
  // below the given depth; zero when every address already fits.
  function automatic int red_steps(input int depth);
    int n;
    n = 0;
    for (int k = 0; k < ADDR_W; k++) begin
      if ((depth << k) <= (1 << ADDR_W) - 1) n = k + 1;
    end
    return n;
  endfunction

endpackage

// ===== src/bltc_ctrl.sv =====
// Controller state machine of the tape machine.
module bltc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  bltc_pkg::func_e    in_func,
  input  logic               out_free,
  input  bltc_pkg::sts_t     sts,
  output logic               s_tready,
  output logic               out_load,
  output bltc_pkg::cmd_t     cmd
);

  bltc_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bltc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bltc_pkg::S_CLEAR: begin
        if (sts.clr_done) state_next = bltc_pkg::S_IDLE;
      end
      bltc_pkg::S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_func) inside
            bltc_pkg::FN_LOAD_PROG, bltc_pkg::FN_WRITE_TAPE,
            bltc_pkg::FN_SET_IP, bltc_pkg::FN_SET_DP: state_next = bltc_pkg::S_RED;
            bltc_pkg::FN_EXEC: state_next = bltc_pkg::S_EXEC;
            default:           state_next = bltc_pkg::S_DONE;
          endcase
        end
      end
      bltc_pkg::S_RED: begin
        if (sts.red_done) state_next = bltc_pkg::S_DONE;
      end
      bltc_pkg::S_EXEC: begin
        state_next = bltc_pkg::S_DONE;
        if (sts.opc == bltc_pkg::OC_OPEN && sts.cell_zero && !sts.ip_last) begin
          state_next = bltc_pkg::S_SCAN;
        end
        if (sts.opc == bltc_pkg::OC_CLOSE && !sts.cell_zero && !sts.ip_zero) begin
          state_next = bltc_pkg::S_SCAN;
        end
      end
      bltc_pkg::S_SCAN: begin
        if (sts.opc == bltc_pkg::OC_OTHER || (sts.scan_target && sts.depth_one) ||
            sts.a_end) begin
          state_next = bltc_pkg::S_DONE;
        end
      end
      bltc_pkg::S_DONE: begin
        if (out_free) state_next = bltc_pkg::S_IDLE;
      end
      default: state_next = bltc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      bltc_pkg::S_CLEAR: begin
        cmd.clr_write = 1'b1;
      end
      bltc_pkg::S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      bltc_pkg::S_RED: begin
        if (sts.red_done) begin
          cmd.apply = 1'b1;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      bltc_pkg::S_EXEC: begin
        unique case (sts.opc)
          bltc_pkg::OC_PLAIN: cmd.exec_plain = 1'b1;
          bltc_pkg::OC_OPEN: begin
            if (!sts.cell_zero) begin
              cmd.exec_plain = 1'b1;
            end else if (sts.ip_last) begin
              cmd.status_wr   = 1'b1;
              cmd.status_code = bltc_pkg::ST_OUT_OF_STORE;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_fwd   = 1'b1;
            end
          end
          bltc_pkg::OC_CLOSE: begin
            if (sts.cell_zero) begin
              cmd.exec_plain = 1'b1;
            end else if (sts.ip_zero) begin
              cmd.status_wr   = 1'b1;
              cmd.status_code = bltc_pkg::ST_OUT_OF_STORE;
            end else begin
              cmd.scan_start = 1'b1;
            end
          end
          default: begin
            cmd.status_wr   = 1'b1;
            cmd.status_code = bltc_pkg::ST_BAD_OP;
          end
        endcase
      end
      bltc_pkg::S_SCAN: begin
        // A match on the last or first address still counts as found.
        if (sts.opc == bltc_pkg::OC_OTHER) begin
          cmd.status_wr   = 1'b1;
          cmd.status_code = bltc_pkg::ST_BAD_SCAN;
        end else if (sts.scan_target && sts.depth_one) begin
          cmd.scan_hit = 1'b1;
        end else if (sts.a_end) begin
          cmd.status_wr   = 1'b1;
          cmd.status_code = bltc_pkg::ST_OUT_OF_STORE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      bltc_pkg::S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/bltc_datapath.sv =====
// Datapath of the tape machine: program store, tape, pointers and scan logic.
module bltc_datapath #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  bltc_pkg::in_t   item,
  input  bltc_pkg::cmd_t  cmd,
  output bltc_pkg::sts_t  sts,
  output bltc_pkg::res_t  res
);

  localparam int PAW      = $clog2(PROG_DEPTH);
  localparam int TAW      = $clog2(TAPE_DEPTH);
  localparam int DW       = PAW + 1;
  localparam int AW       = bltc_pkg::ADDR_W;
  localparam int PROG_RED = bltc_pkg::red_steps(PROG_DEPTH);
  localparam int TAPE_RED = bltc_pkg::red_steps(TAPE_DEPTH);
  localparam logic [PAW-1:0] P_LAST = PAW'(PROG_DEPTH - 1);
  localparam logic [TAW-1:0] T_LAST = TAW'(TAPE_DEPTH - 1);

  logic [7:0] prog_mem [PROG_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];
  logic [7:0] prog_q, tape_q;

  logic [PAW-1:0] ip, a;
  logic [TAW-1:0] dp, clr_cnt;
  logic [DW-1:0]  depth;
  logic           dir;

  bltc_pkg::func_e    func_q;
  logic [AW-1:0]      rv;
  logic [3:0]         red_left;
  logic [7:0]         value_q, io_q;
  bltc_pkg::status_e  status;
  logic               outv;
  logic [7:0]         outb;

  logic [PAW-1:0]  ip_inc, a_next, a_inc, rd_addr, rv_p;
  logic [TAW-1:0]  dp_inc, dp_dec, rv_t;
  logic [PAW+AW-1:0] rv_px, ip_x;
  logic [TAW+AW-1:0] rv_tx, dp_x;
  logic [3:0]      red_k;
  logic [27:0]     red_cand;
  bltc_pkg::op_class_e opc;
  logic            tape_we;
  logic [TAW-1:0]  tape_wa;
  logic [7:0]      tape_wd;

  assign opc    = bltc_pkg::op_class(prog_q);
  assign ip_inc = (ip == P_LAST) ? '0 : ip + 1'b1;
  assign a_inc  = (a == P_LAST) ? '0 : a + 1'b1;
  assign a_next = dir ? a + 1'b1 : a - 1'b1;
  assign dp_inc = (dp == T_LAST) ? '0 : dp + 1'b1;
  assign dp_dec = (dp == '0) ? T_LAST : dp - 1'b1;

  // Addresses were already reduced below the depth, so the low bits suffice.
  assign rv_px = {{PAW{1'b0}}, rv};
  assign rv_tx = {{TAW{1'b0}}, rv};
  assign rv_p  = rv_px[PAW-1:0];
  assign rv_t  = rv_tx[TAW-1:0];

  assign red_k    = red_left - 4'd1;
  assign red_cand = (func_q == bltc_pkg::FN_LOAD_PROG || func_q == bltc_pkg::FN_SET_IP) ?
                    (28'(PROG_DEPTH) << red_k) : (28'(TAPE_DEPTH) << red_k);

  always_comb begin
    if (cmd.scan_step) begin
      rd_addr = a_next;
    end else if (cmd.scan_start) begin
      rd_addr = cmd.scan_fwd ? ip + 1'b1 : ip - 1'b1;
    end else begin
      rd_addr = ip;
    end
  end

  always_comb begin
    tape_we = 1'b0;
    tape_wa = dp;
    tape_wd = tape_q;
    if (cmd.clr_write) begin
      tape_we = 1'b1;
      tape_wa = clr_cnt;
      tape_wd = '0;
    end else if (cmd.apply && func_q == bltc_pkg::FN_WRITE_TAPE) begin
      tape_we = 1'b1;
      tape_wa = rv_t;
      tape_wd = value_q;
    end else if (cmd.exec_plain) begin
      case (prog_q)
        bltc_pkg::OP_INC: begin
          tape_we = 1'b1;
          tape_wd = tape_q + 8'd1;
        end
        bltc_pkg::OP_DEC: begin
          tape_we = 1'b1;
          tape_wd = tape_q - 8'd1;
        end
        bltc_pkg::OP_IN: begin
          tape_we = 1'b1;
          tape_wd = io_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && func_q == bltc_pkg::FN_LOAD_PROG) prog_mem[rv_p] <= value_q;
    prog_q <= prog_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_wa] <= tape_wd;
    tape_q <= tape_mem[dp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip      <= '0;
      dp      <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_write) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.apply && func_q == bltc_pkg::FN_SET_IP) ip <= rv_p;
      if (cmd.apply && func_q == bltc_pkg::FN_SET_DP) dp <= rv_t;
      if (cmd.exec_plain) begin
        ip <= ip_inc;
        if (prog_q == bltc_pkg::OP_RIGHT) dp <= dp_inc;
        if (prog_q == bltc_pkg::OP_LEFT)  dp <= dp_dec;
      end
      // A forward scan resumes after the ']', a backward one at the '['.
      if (cmd.scan_hit) ip <= dir ? a_inc : a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= item.func;
      rv      <= item.addr;
      value_q <= item.value;
      io_q    <= item.io_in;
      status  <= bltc_pkg::ST_OK;
      outv    <= 1'b0;
      outb    <= '0;
      case (item.func) inside
        bltc_pkg::FN_LOAD_PROG, bltc_pkg::FN_SET_IP:  red_left <= 4'(PROG_RED);
        bltc_pkg::FN_WRITE_TAPE, bltc_pkg::FN_SET_DP: red_left <= 4'(TAPE_RED);
        default:                                      red_left <= '0;
      endcase
    end
    if (cmd.red_step) begin
      if ({16'b0, rv} >= red_cand) rv <= rv - red_cand[AW-1:0];
      red_left <= red_k;
    end
    if (cmd.exec_plain && prog_q == bltc_pkg::OP_OUT) begin
      outv <= 1'b1;
      outb <= tape_q;
    end
    if (cmd.status_wr) status <= cmd.status_code;
    if (cmd.scan_start) begin
      a     <= rd_addr;
      dir   <= cmd.scan_fwd;
      depth <= DW'(1);
    end
    if (cmd.scan_step) begin
      a <= a_next;
      if ((dir && opc == bltc_pkg::OC_CLOSE) || (!dir && opc == bltc_pkg::OC_OPEN)) begin
        depth <= depth - 1'b1;
      end else if (opc == bltc_pkg::OC_OPEN || opc == bltc_pkg::OC_CLOSE) begin
        depth <= depth + 1'b1;
      end
    end
  end

  assign sts.clr_done    = (clr_cnt == T_LAST);
  assign sts.red_done    = (red_left == 4'd0);
  assign sts.opc         = opc;
  assign sts.cell_zero   = (tape_q == 8'd0);
  assign sts.ip_last     = (ip == P_LAST);
  assign sts.ip_zero     = (ip == '0);
  assign sts.a_end       = dir ? (a == P_LAST) : (a == '0);
  assign sts.scan_target = dir ? (opc == bltc_pkg::OC_CLOSE) : (opc == bltc_pkg::OC_OPEN);
  assign sts.depth_one   = (depth == DW'(1));

  assign ip_x = {{AW{1'b0}}, ip};
  assign dp_x = {{AW{1'b0}}, dp};

  assign res.status    = status;
  assign res.out_valid = outv;
  assign res.out_byte  = outb;
  assign res.ip_now    = ip_x[AW-1:0];
  assign res.dp_now    = dp_x[AW-1:0];

endmodule

// ===== src/bracket_loop_tape_cpu_top.sv =====
// Top level of the tape machine: stream ports, output register and the two halves.
// An eight-opcode tape machine with a PROG_DEPTH-byte program store and a
// TAPE_DEPTH-byte tape. Each memory has one write port and one read port with a
// registered read. Each input beat yields exactly one result beat. After reset the
// tape is cleared one entry a cycle, and no beat is taken until every entry is
// cleared. A plain instruction or an untaken bracket goes from the accept through
// the execute state to the done state, which loads its result into the output
// register once that is free, and then back to idle for the next beat. An unused
// function code skips the execute state. A taken bracket adds a scan state that
// walks the program, reading one byte a cycle through the program store's read
// port. Loads and pointer sets pass through the reduce state instead of the execute
// state, which, when the depth is below 4096, runs the compare-subtract steps that
// fold the 12-bit address into the store. A new beat is taken once the previous
// result sits in the output register, where it waits for the consumer.
module bracket_loop_tape_cpu_top #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // func [2:0], addr [14:3], value [22:15], io_in [30:23], zero pad [31]
  input  logic [bltc_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status [1:0], out_valid [2], out_byte [10:3], ip_now [22:11], dp_now [34:23],
  // zero pad [39:35]
  output logic [bltc_pkg::OUT_W-1:0]  m_tdata
);

  bltc_pkg::in_t  item;
  bltc_pkg::cmd_t cmd;
  bltc_pkg::sts_t sts;
  bltc_pkg::res_t res;
  logic           out_free, out_load;

  assign item.func  = bltc_pkg::func_e'(s_tdata[2:0]);
  assign item.addr  = s_tdata[14:3];
  assign item.value = s_tdata[22:15];
  assign item.io_in = s_tdata[30:23];

  assign out_free = !m_tvalid || m_tready;

  bltc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_func  (item.func),
    .out_free (out_free),
    .sts      (sts),
    .s_tready (s_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  bltc_datapath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .sts  (sts),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, res.dp_now, res.ip_now, res.out_byte, res.out_valid, res.status};
    end
  end

endmodule

// ===== sim/bracket_loop_tape_cpu_top_tb.sv =====
// Self-checking testbench of the tape machine with a cycle-accurate-free behavioral predictor.
module bracket_loop_tape_cpu_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROG_DEPTH  = 4096;
  localparam int TAPE_DEPTH  = 4096;
  localparam int RANDOM_BEATS = 1250;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  // func [2:0], addr [14:3], value [22:15], io_in [30:23], zero pad [31]
  logic [bltc_pkg::IN_W-1:0]    s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  // status [1:0], out_valid [2], out_byte [10:3], ip_now [22:11], dp_now [34:23],
  // zero pad [39:35]
  logic [bltc_pkg::OUT_W-1:0]   m_tdata;

  bracket_loop_tape_cpu_top #(
    .PROG_DEPTH(PROG_DEPTH),
    .TAPE_DEPTH(TAPE_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #10 clk = ~clk;

  // Predicted machine state.
  logic [7:0]  prog_mem     [PROG_DEPTH];
  bit          prog_written [PROG_DEPTH];
  logic [7:0]  tape_mem     [TAPE_DEPTH];
  logic [11:0] ip_reg;
  logic [11:0] dp_reg;
  int          hole_addr;

  bltc_pkg::res_t expected_results[$];
  bltc_pkg::res_t oldest_result;
  bit   steady_flow = 1'b0;
  int   beats_sent;
  int   exec_beats;
  int   output_bytes;
  int   results_checked;
  int   mismatches;
  int   cycle_count;

  function automatic bit is_plain_op(input logic [7:0] b);
    return b == bltc_pkg::OP_RIGHT || b == bltc_pkg::OP_LEFT || b == bltc_pkg::OP_INC ||
           b == bltc_pkg::OP_DEC || b == bltc_pkg::OP_OUT || b == bltc_pkg::OP_IN;
  endfunction

  function automatic bit is_opcode(input logic [7:0] b);
    return is_plain_op(b) || b == bltc_pkg::OP_OPEN || b == bltc_pkg::OP_CLOSE;
  endfunction

  // A scan that meets a never-written byte notes its address in hole_addr and stops.
  function automatic bltc_pkg::status_e scan_forward(input logic [11:0] origin,
                                                     output logic [11:0] target);
    int a;
    int depth;
    target = origin;
    depth = 1;
    for (a = origin + 1; a < PROG_DEPTH; a++) begin
      if (!prog_written[a]) begin
        hole_addr = a;
        return bltc_pkg::ST_BAD_SCAN;
      end
      if (prog_mem[a] == bltc_pkg::OP_CLOSE) begin
        depth--;
        if (depth == 0) begin
          target = a[11:0] + 12'd1;
          return bltc_pkg::ST_OK;
        end
      end else if (prog_mem[a] == bltc_pkg::OP_OPEN) begin
        depth++;
      end else if (!is_plain_op(prog_mem[a])) begin
        return bltc_pkg::ST_BAD_SCAN;
      end
    end
    return bltc_pkg::ST_OUT_OF_STORE;
  endfunction

  function automatic bltc_pkg::status_e scan_backward(input logic [11:0] origin,
                                                      output logic [11:0] target);
    int a;
    int depth;
    target = origin;
    depth = 1;
    a = origin;
    while (a > 0) begin
      a--;
      if (!prog_written[a]) begin
        hole_addr = a;
        return bltc_pkg::ST_BAD_SCAN;
      end
      if (prog_mem[a] == bltc_pkg::OP_OPEN) begin
        depth--;
        if (depth == 0) begin
          target = a[11:0];
          return bltc_pkg::ST_OK;
        end
      end else if (prog_mem[a] == bltc_pkg::OP_CLOSE) begin
        depth++;
      end else if (!is_plain_op(prog_mem[a])) begin
        return bltc_pkg::ST_BAD_SCAN;
      end
    end
    return bltc_pkg::ST_OUT_OF_STORE;
  endfunction

  // First program address that executing at IP would read before it was written, or -1.
  function automatic int unwritten_read_addr();
    logic [11:0] unused_target;
    hole_addr = -1;
    if (!prog_written[ip_reg]) return int'(ip_reg);
    if (prog_mem[ip_reg] == bltc_pkg::OP_OPEN && tape_mem[dp_reg] == 8'd0)
      void'(scan_forward(ip_reg, unused_target));
    else if (prog_mem[ip_reg] == bltc_pkg::OP_CLOSE && tape_mem[dp_reg] != 8'd0)
      void'(scan_backward(ip_reg, unused_target));
    return hole_addr;
  endfunction

  function automatic bltc_pkg::res_t machine_step(input logic [2:0] fn,
                                                  input logic [11:0] addr,
                                                  input logic [7:0] value,
                                                  input logic [7:0] io);
    bltc_pkg::res_t    r;
    logic [7:0]        cell_val;
    logic [11:0]       next_ip;
    bltc_pkg::status_e st;
    r = '0;
    st = bltc_pkg::ST_OK;
    case (fn)
      bltc_pkg::FN_LOAD_PROG: begin
        prog_mem[addr] = value;
        prog_written[addr] = 1'b1;
      end
      bltc_pkg::FN_WRITE_TAPE: tape_mem[addr] = value;
      bltc_pkg::FN_SET_IP:     ip_reg = addr;
      bltc_pkg::FN_SET_DP:     dp_reg = addr;
      bltc_pkg::FN_EXEC: begin
        exec_beats++;
        cell_val = tape_mem[dp_reg];
        next_ip = ip_reg + 12'd1;
        case (prog_mem[ip_reg])
          bltc_pkg::OP_RIGHT: dp_reg = dp_reg + 12'd1;
          bltc_pkg::OP_LEFT:  dp_reg = dp_reg - 12'd1;
          bltc_pkg::OP_INC:   tape_mem[dp_reg] = cell_val + 8'd1;
          bltc_pkg::OP_DEC:   tape_mem[dp_reg] = cell_val - 8'd1;
          bltc_pkg::OP_OUT: begin
            r.out_valid = 1'b1;
            r.out_byte = cell_val;
            output_bytes++;
          end
          bltc_pkg::OP_IN:    tape_mem[dp_reg] = io;
          bltc_pkg::OP_OPEN:  if (cell_val == 8'd0) st = scan_forward(ip_reg, next_ip);
          bltc_pkg::OP_CLOSE: if (cell_val != 8'd0) st = scan_backward(ip_reg, next_ip);
          default:            st = bltc_pkg::ST_BAD_OP;
        endcase
        if (st == bltc_pkg::ST_OK) ip_reg = next_ip;
      end
      default: ;
    endcase
    r.status = st;
    r.ip_now = ip_reg;
    r.dp_now = dp_reg;
    return r;
  endfunction

  function automatic logic [7:0] plain_op();
    case ($urandom_range(5))
      0:       return bltc_pkg::OP_RIGHT;
      1:       return bltc_pkg::OP_LEFT;
      2:       return bltc_pkg::OP_INC;
      3:       return bltc_pkg::OP_DEC;
      4:       return bltc_pkg::OP_OUT;
      default: return bltc_pkg::OP_IN;
    endcase
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_opcode(b));
    return b;
  endfunction

  function automatic logic [7:0] filler_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return bltc_pkg::OP_OPEN;
    if (pick < 16) return bltc_pkg::OP_CLOSE;
    if (pick < 26) return junk_byte();
    return plain_op();
  endfunction

  // Drives one beat and returns at the edge that accepts it; valid stays high afterwards.
  task automatic send_beat(input logic [2:0] fn, input logic [11:0] addr,
                           input logic [7:0] value, input logic [7:0] io);
    bltc_pkg::res_t predicted;
    if (!steady_flow && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tdata  <= {1'b0, io, value, addr, fn};
    s_tvalid <= 1'b1;
    predicted = machine_step(fn, addr, value, io);
    beats_sent++;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predicted);
  endtask

  // Executes at IP, first loading any program byte the instruction would read unwritten.
  task automatic exec_step(input logic [7:0] io);
    int hole;
    hole = unwritten_read_addr();
    while (hole >= 0) begin
      send_beat(bltc_pkg::FN_LOAD_PROG, hole[11:0], filler_byte(), 8'($urandom_range(255)));
      hole = unwritten_read_addr();
    end
    send_beat(bltc_pkg::FN_EXEC, 12'($urandom_range(4095)), 8'($urandom_range(255)), io);
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_beat(FN_UNUSED_LAST, 12'hFFF, 8'hFF, 8'hFF);
  endtask

  // Output, increment with wrap, DP wrap both ways, input and decrement.
  task automatic test_plain_ops();
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd0, bltc_pkg::OP_OUT, 8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd1, bltc_pkg::OP_INC, 8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd2, bltc_pkg::OP_LEFT, 8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd3, bltc_pkg::OP_IN, 8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd4, bltc_pkg::OP_RIGHT, 8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd5, bltc_pkg::OP_DEC, 8'h00);
    exec_step(8'h00);
    send_beat(bltc_pkg::FN_WRITE_TAPE, 12'd0, 8'hFF, 8'h00);
    exec_step(8'h00);
    exec_step(8'h00);
    exec_step(8'hFF);
    exec_step(8'h00);
    exec_step(8'h00);
  endtask

  // A backward scan that runs off address 0, one that matches at address 0, and a
  // forward match on the last address that wraps IP to zero.
  task automatic test_bracket_jumps();
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd6, bltc_pkg::OP_CLOSE, 8'h00);
    exec_step(8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd0, bltc_pkg::OP_OPEN, 8'h00);
    exec_step(8'h00);
    exec_step(8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd4094, bltc_pkg::OP_OPEN, 8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd4095, bltc_pkg::OP_CLOSE, 8'h00);
    send_beat(bltc_pkg::FN_WRITE_TAPE, 12'd0, 8'h00, 8'h00);
    send_beat(bltc_pkg::FN_SET_IP, 12'd4094, 8'h00, 8'h00);
    exec_step(8'h00);
  endtask

  // Forward scan past the end, unknown byte inside a scan, unknown opcode.
  task automatic test_scan_errors();
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd4093, bltc_pkg::OP_OPEN, 8'h00);
    send_beat(bltc_pkg::FN_SET_IP, 12'd4093, 8'h00, 8'h00);
    exec_step(8'h00);
    send_beat(bltc_pkg::FN_LOAD_PROG, 12'd4094, 8'h00, 8'h00);
    exec_step(8'h00);
    send_beat(bltc_pkg::FN_SET_IP, 12'd4094, 8'h00, 8'h00);
    exec_step(8'h00);
  endtask

  task automatic test_unused_funcs();
    for (int fn = int'(FN_UNUSED_FIRST); fn <= int'(FN_UNUSED_LAST); fn++)
      send_beat(fn[2:0], 12'($urandom_range(4095)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
  endtask

  // Loads a short program with balanced brackets (now and then a stray byte), seeds a
  // few tape cells, points IP at it and runs a bounded number of steps.
  task automatic run_program();
    int          len;
    int          base;
    int          opens;
    int          pick;
    logic [7:0]  b;
    logic [11:0] dp_start;
    len = $urandom_range(6, 20);
    base = $urandom_range(PROG_DEPTH - 1 - len);
    opens = 0;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (opens == len - i) begin
        b = bltc_pkg::OP_CLOSE;
        opens--;
      end else if (pick < 14 && opens + 1 < len - i) begin
        b = bltc_pkg::OP_OPEN;
        opens++;
      end else if (pick < 28 && opens > 0) begin
        b = bltc_pkg::OP_CLOSE;
        opens--;
      end else if (pick < 31) begin
        b = junk_byte();
      end else begin
        b = plain_op();
      end
      send_beat(bltc_pkg::FN_LOAD_PROG, 12'(base + i), b, 8'($urandom_range(255)));
    end
    dp_start = 12'($urandom_range(4095));
    send_beat(bltc_pkg::FN_SET_DP, dp_start, 8'($urandom_range(255)),
              8'($urandom_range(255)));
    for (int i = 0; i < 3; i++)
      send_beat(bltc_pkg::FN_WRITE_TAPE, 12'(dp_start + i), 8'($urandom_range(7)),
                8'($urandom_range(255)));
    send_beat(bltc_pkg::FN_SET_IP, 12'(base), 8'($urandom_range(255)),
              8'($urandom_range(255)));
    repeat ($urandom_range(8, 40)) exec_step(8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    logic [2:0] fn;
    repeat ($urandom_range(4, 12)) begin
      fn = 3'($urandom_range(7));
      if (fn == bltc_pkg::FN_EXEC)
        exec_step(8'($urandom_range(255)));
      else if (fn == bltc_pkg::FN_LOAD_PROG)
        send_beat(fn, 12'($urandom_range(4095)), filler_byte(), 8'($urandom_range(255)));
      else
        send_beat(fn, 12'($urandom_range(4095)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_programs();
    int start;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      steady_flow = (beats_sent - start >= 400) && (beats_sent - start < 600);
      if ($urandom_range(99) < 80) run_program();
      else send_noise();
      if ($urandom_range(7) == 0) pause_until_drained();
    end
    steady_flow = 1'b0;
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result beat with nothing expected: %h", m_tdata);
      end else begin
        oldest_result = expected_results.pop_front();
        results_checked++;
        if (m_tdata[1:0] !== oldest_result.status ||
            m_tdata[2] !== oldest_result.out_valid ||
            m_tdata[10:3] !== oldest_result.out_byte ||
            m_tdata[22:11] !== oldest_result.ip_now ||
            m_tdata[34:23] !== oldest_result.dp_now) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d: expected st=%0d ov=%0b ob=%h ip=%h dp=%h,",
                     results_checked, oldest_result.status, oldest_result.out_valid,
                     oldest_result.out_byte, oldest_result.ip_now, oldest_result.dp_now);
            $display("  got st=%0d ov=%0b ob=%h ip=%h dp=%h",
                     m_tdata[1:0], m_tdata[2], m_tdata[10:3], m_tdata[22:11],
                     m_tdata[34:23]);
          end
        end
      end
    end
    m_tready <= steady_flow || ($urandom_range(99) >= 27);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("bracket_loop_tape_cpu_top regression: fail");
    $finish;
  end

  initial begin
    foreach (tape_mem[i]) begin
      tape_mem[i] = 8'd0;
      prog_mem[i] = 8'd0;
      prog_written[i] = 1'b0;
    end
    ip_reg = '0;
    dp_reg = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_plain_ops();
    test_bracket_jumps();
    test_scan_errors();
    test_unused_funcs();
    pause_until_drained();
    test_random_programs();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    $display("Sent %0d beats (%0d instruction executions, %0d output bytes);",
             beats_sent, exec_beats, output_bytes);
    $display("checked %0d result beats with receiver stalls, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0)
      $display("bracket_loop_tape_cpu_top regression: pass");
    else
      $display("bracket_loop_tape_cpu_top regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/bltc_pkg.sv
src/bltc_ctrl.sv
src/bltc_datapath.sv
src/bracket_loop_tape_cpu_top.sv
sim/bracket_loop_tape_cpu_top_tb.sv
